// File: hw/rtl/tbst_pkg.sv
// shared constants, codes and control structs for the track block speed trap
`default_nettype none
package tbst_pkg;

  // time and arithmetic widths
  localparam int TIME_BITS  = 32;
  localparam int NOW_BITS   = 32;
  localparam int LEN_BITS   = 16;
  localparam int BLOCK_BITS = 8;
  localparam int LOCO_BITS  = 16;
  localparam int SPEED_BITS = 16;
  localparam int SCALE      = 1000;
  localparam int SCALE_BITS = 10;
  localparam int NUM_BITS   = LEN_BITS + SCALE_BITS;
  localparam int CNT_BITS   = $clog2(NUM_BITS);

  // stream and config port widths
  localparam int IN_FIELD_BITS  = LOCO_BITS + 2 + NOW_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = BLOCK_BITS + LOCO_BITS + SPEED_BITS + 1;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_BITS   = 1;
  localparam int CFG_DATA_BITS  = LEN_BITS;

  // operation codes carried in tuser
  localparam logic OP_ARM  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_LENGTH = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK  = 1'b1;

  // register reset values
  localparam logic [LEN_BITS-1:0]   LENGTH_RESET = LEN_BITS'(1000);
  localparam logic [BLOCK_BITS-1:0] BLOCK_RESET  = '0;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic set_entry;
    logic start_div;
    logic load_out;
    logic last;
    logic update_levels;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic op_tick;
    logic armed;
    logic rise_one;
    logic fall_one;
    logic rise_two;
    logic fall_two;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/track_block_speed_trap.sv
// top level of the two-gate speed trap for one track block
// usage:
//   s_* carries input beats: tuser is the op (0 arm, 1 sample tick), tdata
//   holds the locomotive number, both sensor levels and the millisecond time.
//   m_* carries report beats; tlast marks the final report of an input beat.
//   cfg_* writes register 0 (block length in mm) or 1 (block number); it is
//   always ready and meant to be used while the block is idle.
// timing:
//   an arm beat, or a tick while disarmed, is done when it is taken; an armed
//   tick without a report steps through the one, two and done states. each
//   report runs the bit-serial divider, one quotient bit per cycle over 26
//   bits, and then waits in the emit state for a free output register.
//   s_tready is high only between beats, one input beat is worked on at a
//   time.
// reset:
//   rst (synchronous) disarms, clears entry time, locomotive and levels, and
//   restores the block length to 1000 mm and the block number to 0.
// stall:
//   a report sits in the output register until taken; while m_tready is low a
//   following report waits for the register, and no input beat is accepted
//   until the tick that gives it has finished.
`default_nettype none
module track_block_speed_trap (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // cfg_index: 0 block_length_mm, 1 block_number
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tbst_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [tbst_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // s_tdata: loco_number[15:0], sensor_one[16], sensor_two[17], now_ms[49:18]
  input  wire logic [tbst_pkg::IN_TDATA_BITS-1:0]  s_tdata,
  // s_tuser: op[0]
  input  wire logic                                s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // m_tdata: report_block[7:0], report_loco[23:8], speed_mm_per_s[39:24],
  //          saturated[40]
  output logic [tbst_pkg::OUT_TDATA_BITS-1:0]      m_tdata,
  output logic                                     m_tlast
);
  import tbst_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  // controller
  tbst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  tbst_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

// File: hw/rtl/tbst_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module tbst_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [tbst_pkg::NUM_BITS-1:0]  dividend,
  input  wire logic [tbst_pkg::TIME_BITS-1:0] divisor,
  output logic                               busy,
  output logic                               done,
  output logic [tbst_pkg::NUM_BITS-1:0]       quotient
);
  import tbst_pkg::*;

  logic [NUM_BITS-1:0]  quo;
  logic [TIME_BITS-1:0] rem;
  logic [TIME_BITS-1:0] dsr;
  logic [CNT_BITS-1:0]  count;
  logic [TIME_BITS:0]   trial;
  logic [TIME_BITS:0]   diff;
  logic                 take;

  // trial subtract of the shifted remainder
  assign trial = {rem, quo[NUM_BITS-1]};
  assign diff  = trial - {1'b0, dsr};
  assign take  = trial >= {1'b0, dsr};

  // control: busy flag, step count, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_BITS'(NUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[NUM_BITS-2:0], take};
      rem <= take ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
    end
  end

  assign quotient = quo;

  // a new division never starts on top of a running one
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");

  // done follows the final step of a run
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a run");

endmodule
`default_nettype wire

// File: hw/rtl/tbst_ctrl.sv
// sequencing controller: sensor one, sensor two, divide and report
`default_nettype none
module tbst_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire tbst_pkg::stat_t stat,
  output tbst_pkg::cmd_t       cmd
);
  import tbst_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ONE  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_TWO  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       which_two;
  logic       which_two_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      which_two <= 1'b0;
    end else begin
      state     <= state_next;
      which_two <= which_two_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next     = state;
    which_two_next = which_two;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (stat.op_tick && stat.armed) begin
            state_next = ST_ONE;
          end
        end
      end
      ST_ONE: begin
        cmd.set_entry = stat.rise_one;
        if (stat.fall_one) begin
          cmd.start_div  = 1'b1;
          which_two_next = 1'b0;
          state_next     = ST_DIV;
        end else begin
          state_next = ST_TWO;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.last     = which_two || !stat.fall_two;
          state_next   = which_two ? ST_DONE : ST_TWO;
        end
      end
      ST_TWO: begin
        cmd.set_entry = stat.rise_two;
        if (stat.fall_two) begin
          cmd.start_div  = 1'b1;
          which_two_next = 1'b1;
          state_next     = ST_DIV;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.update_levels = 1'b1;
        state_next        = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // a report never goes out before its division has finished
  a_emit_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && $past(state) != ST_EMIT |-> $past(state) == ST_DIV)
    else $error("emit entered without division");

  // levels update only at the end of a sample tick
  a_levels_at_end: assert property (@(posedge clk) disable iff (rst)
    cmd.update_levels |=> state == ST_IDLE)
    else $error("level update outside tick end");

endmodule
`default_nettype wire

// File: hw/rtl/tbst_dp.sv
// datapath: config, trap state, sample capture, divider and output register
`default_nettype none
module tbst_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  input  wire logic [tbst_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [tbst_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic [tbst_pkg::IN_TDATA_BITS-1:0]  s_tdata,
  input  wire logic                                s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [tbst_pkg::OUT_TDATA_BITS-1:0]      m_tdata,
  output logic                                     m_tlast,
  input  wire tbst_pkg::cmd_t                      cmd,
  output tbst_pkg::stat_t                          stat
);
  import tbst_pkg::*;

  // configuration registers
  logic [LEN_BITS-1:0]   cfg_length;
  logic [BLOCK_BITS-1:0] cfg_block;

  // trap state
  logic                 armed;
  logic [TIME_BITS-1:0] entry_time;
  logic [LOCO_BITS-1:0] armed_loco;
  logic                 last_level_one;
  logic                 last_level_two;

  // captured sample
  logic                 smp_one;
  logic                 smp_two;
  logic [TIME_BITS-1:0] smp_now;

  // input field slices
  logic [LOCO_BITS-1:0] in_loco;
  logic                 in_one;
  logic                 in_two;
  logic [NOW_BITS-1:0]  in_now;

  // division
  logic [TIME_BITS-1:0] elapsed;
  logic                 elapsed_zero;
  logic [NUM_BITS-1:0]  numer;
  logic                 div_busy;
  logic                 div_done;
  logic [NUM_BITS-1:0]  quotient;
  logic                 sat;
  logic [SPEED_BITS-1:0] speed;

  // output register
  logic [BLOCK_BITS-1:0] out_block;
  logic [LOCO_BITS-1:0]  out_loco;
  logic [SPEED_BITS-1:0] out_speed;
  logic                  out_sat;
  logic                  out_last;
  logic                  out_free;

  assign in_loco = s_tdata[LOCO_BITS-1:0];
  assign in_one  = s_tdata[LOCO_BITS];
  assign in_two  = s_tdata[LOCO_BITS+1];
  assign in_now  = s_tdata[LOCO_BITS+2 +: NOW_BITS];

  // config writes, always ready
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_length <= LENGTH_RESET;
      cfg_block  <= BLOCK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LENGTH: cfg_length <= cfg_data;
        REG_BLOCK:  cfg_block  <= cfg_data[BLOCK_BITS-1:0];
        default:    ;
      endcase
    end
  end

  // trap state: arm, entry time, disarm on report, level update
  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= 1'b0;
      entry_time     <= '0;
      armed_loco     <= '0;
      last_level_one <= 1'b0;
      last_level_two <= 1'b0;
    end else begin
      if (cmd.accept && s_tuser == OP_ARM) begin
        armed      <= 1'b1;
        armed_loco <= in_loco;
      end else if (cmd.load_out) begin
        armed <= 1'b0;
      end
      if (cmd.set_entry) begin
        entry_time <= smp_now;
      end
      if (cmd.update_levels) begin
        last_level_one <= smp_one;
        last_level_two <= smp_two;
      end
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      smp_one <= in_one;
      smp_two <= in_two;
      smp_now <= TIME_BITS'(in_now);
    end
  end

  // elapsed time and numerator for the divider
  assign elapsed = smp_now - entry_time;
  assign numer   = NUM_BITS'(cfg_length) * NUM_BITS'(SCALE);

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      elapsed_zero <= (elapsed == '0);
    end
  end

  tbst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .dividend (numer),
    .divisor  (elapsed),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  // saturate on zero time or a quotient above the speed range
  assign sat   = elapsed_zero || (|quotient[NUM_BITS-1:SPEED_BITS]);
  assign speed = sat ? '1 : quotient[SPEED_BITS-1:0];

  // output register, freed when the beat is taken
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_block <= cfg_block;
      out_loco  <= armed_loco;
      out_speed <= speed;
      out_sat   <= sat;
      out_last  <= cmd.last;
    end
  end

  assign m_tdata = OUT_TDATA_BITS'({out_sat, out_speed, out_loco, out_block});
  assign m_tlast = out_last;

  // status to the controller
  always_comb begin
    stat          = '0;
    stat.op_tick  = (s_tuser == OP_TICK);
    stat.armed    = armed;
    stat.rise_one = smp_one && !last_level_one;
    stat.fall_one = !smp_one && last_level_one;
    stat.rise_two = smp_two && !last_level_two;
    stat.fall_two = !smp_two && last_level_two;
    stat.div_done = div_done;
    stat.out_free = out_free;
  end

  // a report never overwrites a beat still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("output beat overwritten");

  // a report always leaves the trap disarmed
  a_disarm: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> !armed)
    else $error("trap still armed after report");

endmodule
`default_nettype wire
